>>> rtl/core/bwrs_pkg.sv
// ----------------------------------------------------------------------------
// bwrs_pkg: shared types and constants of the beta-weighted return sum
// Field widths, item kind codes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bwrs_pkg;

  localparam int MAX_PRODUCTS = 64;
  localparam int KIND_W       = 2;
  localparam int INDEX_W      = 6;
  localparam int VALUE_W      = 24;
  localparam int COUNT_W      = 7;
  localparam int SUM_W        = 56;
  localparam int DELTA_W      = VALUE_W + 1;
  localparam int TERM_W       = VALUE_W + DELTA_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_UPDATE = 2'd0,
    KIND_INTR   = 2'd1,
    KIND_LOAD   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_INTR,
    S_WRD,
    S_WMUL,
    S_WACC
  } state_t;

  typedef struct packed {
    logic accept;
    logic ret_wr;
    logic term_upd;
    logic set_ready;
    logic walk_start;
    logic walk_rd;
    logic term_walk;
    logic walk_step;
    logic set_all;
    logic sum_add;
    logic intr_clr;
    logic out_load;
    logic out_zero;
  } cmd_t;

  typedef struct packed {
    logic is_update;
    logic is_intr;
    logic in_range;
    logic all_ready;
    logic ready_after;
    logic load_ok;
    logic walk_last;
  } stat_t;

endpackage

>>> rtl/core/bwrs_if.sv
// ----------------------------------------------------------------------------
// bwrs_if: valid/ready channels of the beta-weighted return sum
// One interface for input items, one for result items.
// ----------------------------------------------------------------------------
interface bwrs_in_if;
  logic                                valid;
  logic                                ready;
  logic [bwrs_pkg::KIND_W-1:0]         kind;
  logic [bwrs_pkg::INDEX_W-1:0]        product_index;
  logic signed [bwrs_pkg::VALUE_W-1:0] sample_value;

  modport source (output valid, output kind, output product_index,
                  output sample_value, input ready);
  modport sink   (input valid, input kind, input product_index,
                  input sample_value, output ready);
endinterface

interface bwrs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bwrs_pkg::SUM_W-1:0] weighted_sum;

  modport source (output valid, output weighted_sum, input ready);
  modport sink   (input valid, input weighted_sum, output ready);
endinterface

>>> rtl/core/bwrs_ctrl.sv
// ----------------------------------------------------------------------------
// bwrs_ctrl: item sequencer of the beta-weighted return sum
// Accepts items, steps the update, interrupt and recompute sequences and
// issues datapath commands.
// ----------------------------------------------------------------------------
module bwrs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bwrs_pkg::stat_t  stat,
  output bwrs_pkg::cmd_t   cmd
);

  bwrs_pkg::state_t state_r, state_nxt;
  logic             acc;

  assign in_ready = rst_n &&
                    ((state_r == bwrs_pkg::S_IDLE) ||
                     ((state_r == bwrs_pkg::S_ADD) && stat.load_ok));
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bwrs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // dispatch on an accepted item, otherwise fall back to idle
  function automatic bwrs_pkg::state_t dispatch(input logic a, input bwrs_pkg::stat_t s);
    bwrs_pkg::state_t n;
    n = bwrs_pkg::S_IDLE;
    if (a && s.in_range && s.is_update) begin
      n = bwrs_pkg::S_MUL;
    end else if (a && s.in_range && s.is_intr) begin
      n = bwrs_pkg::S_INTR;
    end
    return n;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bwrs_pkg::S_IDLE: begin
        state_nxt = dispatch(acc, stat);
      end
      bwrs_pkg::S_MUL: begin
        priority if (stat.all_ready) begin
          state_nxt = bwrs_pkg::S_ADD;
        end else if (stat.ready_after) begin
          state_nxt = bwrs_pkg::S_WRD;
        end else begin
          state_nxt = bwrs_pkg::S_IDLE;
        end
      end
      bwrs_pkg::S_ADD: begin
        if (stat.load_ok) begin
          state_nxt = dispatch(acc, stat);
        end
      end
      bwrs_pkg::S_INTR: begin
        if (stat.load_ok) begin
          state_nxt = bwrs_pkg::S_IDLE;
        end
      end
      bwrs_pkg::S_WRD:  state_nxt = bwrs_pkg::S_WMUL;
      bwrs_pkg::S_WMUL: state_nxt = bwrs_pkg::S_WACC;
      bwrs_pkg::S_WACC: begin
        state_nxt = stat.walk_last ? bwrs_pkg::S_IDLE : bwrs_pkg::S_WRD;
      end
      default: state_nxt = bwrs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.accept = acc;
    unique case (state_r)
      bwrs_pkg::S_IDLE: begin
      end
      bwrs_pkg::S_MUL: begin
        cmd.ret_wr = 1'b1;
        if (stat.all_ready) begin
          cmd.term_upd = 1'b1;
        end else begin
          cmd.set_ready  = 1'b1;
          cmd.walk_start = stat.ready_after;
        end
      end
      bwrs_pkg::S_ADD: begin
        cmd.sum_add  = stat.load_ok;
        cmd.out_load = stat.load_ok;
      end
      bwrs_pkg::S_INTR: begin
        cmd.intr_clr = stat.load_ok;
        cmd.out_load = stat.load_ok;
        cmd.out_zero = 1'b1;
      end
      bwrs_pkg::S_WRD:  cmd.walk_rd = 1'b1;
      bwrs_pkg::S_WMUL: cmd.term_walk = 1'b1;
      bwrs_pkg::S_WACC: begin
        cmd.sum_add   = 1'b1;
        cmd.walk_step = 1'b1;
        cmd.set_all   = stat.walk_last;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/bwrs_dp.sv
// ----------------------------------------------------------------------------
// bwrs_dp: datapath of the beta-weighted return sum
// Beta and return memories, ready marks, shared multiplier, running sum
// and the result register.
// ----------------------------------------------------------------------------
module bwrs_dp #(
  parameter int MAX_PRODUCTS = bwrs_pkg::MAX_PRODUCTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bwrs_pkg::COUNT_W-1:0]        cfg_wr_data,
  input  logic [bwrs_pkg::KIND_W-1:0]         in_kind,
  input  logic [bwrs_pkg::INDEX_W-1:0]        in_product_index,
  input  logic signed [bwrs_pkg::VALUE_W-1:0] in_sample_value,
  input  bwrs_pkg::cmd_t                      cmd,
  output bwrs_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bwrs_pkg::SUM_W-1:0]   out_weighted_sum
);

  localparam int AW = (MAX_PRODUCTS > 1) ? $clog2(MAX_PRODUCTS) : 1;
  localparam int CW = $clog2(MAX_PRODUCTS + 1);
  localparam int VW = bwrs_pkg::VALUE_W;
  localparam int DW = bwrs_pkg::DELTA_W;
  localparam int TW = bwrs_pkg::TERM_W;
  localparam int SW = bwrs_pkg::SUM_W;

  logic [VW-1:0]           beta_mem [MAX_PRODUCTS];
  logic [VW-1:0]           ret_mem  [MAX_PRODUCTS];

  logic [bwrs_pkg::COUNT_W-1:0] count_r;
  logic [CW-1:0]           eff_cnt;
  logic [MAX_PRODUCTS-1:0] in_use;
  logic [MAX_PRODUCTS-1:0] ready_r;
  logic [MAX_PRODUCTS-1:0] ret_vld_r;
  logic [MAX_PRODUCTS-1:0] idx_hot;
  logic                    all_ready_r;
  logic [AW-1:0]           in_addr, rd_addr, idx_r, cnt_r;
  logic                    rd_en, beta_we;
  logic [VW-1:0]           val_r, beta_rd_r, ret_rd_r, ret_eff;
  logic                    ret_rd_vld_r;
  logic signed [DW-1:0]    delta, mul_b;
  logic signed [TW-1:0]    mul_p, term_r;
  logic [SW-1:0]           sum_r, sum_plus;
  logic                    out_valid_r;
  logic [SW-1:0]           out_sum_r;
  logic                    in_range;

  // clamp the configured count to the table depth
  always_comb begin
    if (32'(count_r) > MAX_PRODUCTS) begin
      eff_cnt = CW'(MAX_PRODUCTS);
    end else begin
      eff_cnt = CW'(count_r);
    end
    for (int i = 0; i < MAX_PRODUCTS; i++) begin
      in_use[i] = (i < 32'(eff_cnt));
    end
  end

  assign in_range = 32'(in_product_index) < 32'(eff_cnt);
  assign in_addr  = AW'(in_product_index);
  assign beta_we  = cmd.accept && in_range && (in_kind == bwrs_pkg::KIND_LOAD);
  assign rd_en    = cmd.accept || cmd.walk_rd;
  assign rd_addr  = cmd.walk_rd ? cnt_r : in_addr;
  assign idx_hot  = MAX_PRODUCTS'(1) << idx_r;

  always_ff @(posedge clk) begin
    if (beta_we) begin
      beta_mem[in_addr] <= in_sample_value;
    end
    if (cmd.ret_wr) begin
      ret_mem[idx_r] <= val_r;
    end
    if (rd_en) begin
      beta_rd_r    <= beta_mem[rd_addr];
      ret_rd_r     <= ret_mem[rd_addr];
      ret_rd_vld_r <= ret_vld_r[rd_addr];
    end
  end

  // a return never written reads as zero
  assign ret_eff  = ret_rd_vld_r ? ret_rd_r : '0;
  assign delta    = $signed({val_r[VW-1], val_r}) - $signed({ret_eff[VW-1], ret_eff});
  assign mul_b    = cmd.term_walk ? $signed({ret_eff[VW-1], ret_eff}) : delta;
  assign mul_p    = $signed(beta_rd_r) * mul_b;
  assign sum_plus = sum_r + {{(SW-TW){term_r[TW-1]}}, term_r};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= in_addr;
      val_r <= in_sample_value;
    end
    if (cmd.term_upd || cmd.term_walk) begin
      term_r <= mul_p;
    end
    if (cmd.out_load) begin
      out_sum_r <= cmd.out_zero ? '0 : sum_plus;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ready_r     <= '0;
      ret_vld_r   <= '0;
      all_ready_r <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (cmd.ret_wr) begin
        ret_vld_r <= ret_vld_r | idx_hot;
      end
      if (cmd.set_ready) begin
        ready_r <= ready_r | idx_hot;
      end
      if (cmd.walk_start) begin
        sum_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.sum_add) begin
        sum_r <= sum_plus;
      end
      if (cmd.walk_step) begin
        cnt_r <= cnt_r + AW'(1);
      end
      if (cmd.set_all) begin
        all_ready_r <= 1'b1;
      end
      if (cmd.intr_clr) begin
        sum_r       <= '0;
        all_ready_r <= 1'b0;
        ready_r     <= ready_r & ~idx_hot;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.is_update   = (in_kind == bwrs_pkg::KIND_UPDATE);
    stat.is_intr     = (in_kind == bwrs_pkg::KIND_INTR);
    stat.in_range    = in_range;
    stat.all_ready   = all_ready_r;
    stat.ready_after = &(ready_r | idx_hot | ~in_use);
    stat.load_ok     = !out_valid_r || out_ready;
    stat.walk_last   = (32'(cnt_r) == 32'(eff_cnt) - 1);
  end

  assign out_valid        = out_valid_r;
  assign out_weighted_sum = out_sum_r;

endmodule

>>> rtl/core/beta_weighted_return_sum.sv
// ----------------------------------------------------------------------------
// beta_weighted_return_sum: running beta-weighted sum of product returns
// Keeps a beta and a last return per product, tracks which products have
// reported and maintains sum(beta * return) incrementally once all have.
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake       payload
//  in_ch        sink       valid / ready   kind, product_index, sample_value
//  out_ch       source     valid / ready   weighted_sum
//  cfg_*        in         cfg_wr_en       cfg_wr_data (product_count)
//
//  Steps: an update once all products are ready reads at accept, then
//  multiplies, then adds while the next item is taken, bounded by the one
//  multiplier and the single read port of the return memory. A beta load
//  or an ignored item needs no step after accept; an interrupt passes through
//  its clear step, and an early update only records its return and ready mark.
//  The update that makes the last product ready adds a recompute over the
//  products in use (read, multiply, accumulate per product). Reset clears
//  marks, sum and count at once; betas stay undefined until loaded. A stalled
//  result holds in the output register; a full update or an interrupt then
//  waits at its last step and no further item is taken until the register frees.
//
module beta_weighted_return_sum #(
  parameter int MAX_PRODUCTS = bwrs_pkg::MAX_PRODUCTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [bwrs_pkg::COUNT_W-1:0] cfg_wr_data,
  bwrs_in_if.sink                      in_ch,
  bwrs_out_if.source                   out_ch
);

  bwrs_pkg::cmd_t  cmd;
  bwrs_pkg::stat_t stat;

  // sequencer: owns the input handshake and steps each item
  bwrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: memories, marks, multiplier, sum and result register
  bwrs_dp #(
    .MAX_PRODUCTS (MAX_PRODUCTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_kind          (in_ch.kind),
    .in_product_index (in_ch.product_index),
    .in_sample_value  (in_ch.sample_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_weighted_sum (out_ch.weighted_sum)
  );

endmodule

>>> rtl/core/bwrs_check.sv
// ----------------------------------------------------------------------------
// bwrs_check: port-level checks of the beta-weighted return sum
// Result channel behaviour over time, bound to the top level.
// ----------------------------------------------------------------------------
module bwrs_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bwrs_pkg::SUM_W-1:0] out_sum
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sum))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result must trace back to an accepted item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) ||
                         $past(in_valid && in_ready, 3))
    else $error("result without a recent item");

endmodule

bind beta_weighted_return_sum bwrs_check u_bwrs_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_sum   (out_ch.weighted_sum)
);
